### sv/tsp_pkg.sv
// ---------------------------------------------------------------------------
// tsp_pkg
// Shared types, constants and helpers for the time specification parser.
// ---------------------------------------------------------------------------
package tsp_pkg;

  localparam int MANTISSA_BITS_DEF   = 44;
  localparam int MAX_FRAC_DIGITS_DEF = 12;

  // widest unit multiplier (604800) fits in 20 bits
  localparam int MULT_W   = 20;
  localparam int SECS_W   = 64;
  localparam int PLACES_W = 4;
  localparam int STATUS_W = 2;

  localparam logic [MULT_W-1:0] MULT_SEC  = MULT_W'(1);
  localparam logic [MULT_W-1:0] MULT_MIN  = MULT_W'(60);
  localparam logic [MULT_W-1:0] MULT_HOUR = MULT_W'(3600);
  localparam logic [MULT_W-1:0] MULT_DAY  = MULT_W'(86400);
  localparam logic [MULT_W-1:0] MULT_WEEK = MULT_W'(604800);

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_M  = 8'h6D;
  localparam logic [7:0] CHAR_LC_H  = 8'h68;
  localparam logic [7:0] CHAR_LC_D  = 8'h64;
  localparam logic [7:0] CHAR_LC_W  = 8'h77;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CHAR_ZERO:CHAR_NINE]};
  endfunction

  function automatic logic [MULT_W-1:0] unit_mult(input logic [7:0] c);
    logic [7:0] lc;
    lc = (c inside {[CHAR_UC_A:CHAR_UC_Z]}) ? (c | CASE_BIT) : c;
    case (lc)
      CHAR_LC_M: return MULT_MIN;
      CHAR_LC_H: return MULT_HOUR;
      CHAR_LC_D: return MULT_DAY;
      CHAR_LC_W: return MULT_WEEK;
      default:   return MULT_SEC;
    endcase
  endfunction

endpackage

### sv/time_spec_parser.sv
// ---------------------------------------------------------------------------
// time_spec_parser
// Decimal duration parser with unit suffix: one character per item, one
// fixed-point result (seconds scaled by 10^places) per specification.
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o  | char_code_i, has_char_i, is_last_i
//  out     | output    | out_valid_o / out_stall_i| scaled_seconds_o, decimal_places_o,
//          |           |                        | status_o
//
//  One character item is taken every cycle while no last-character item is
//  waiting on the result side. Input register, then the parse state update
//  (multiply by ten and add), then a snapshot register on the last character,
//  then the 44x20 unit multiply into the output register.
//  Reset clears the parse state and all valid flags.
//  A stalled result holds back only last-character items; other characters
//  keep flowing into the parse state until a held last item blocks the input.
// ---------------------------------------------------------------------------
module time_spec_parser
  import tsp_pkg::*;
#(
  parameter int MANTISSA_BITS   = MANTISSA_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          char_code_i,
  input  logic                has_char_i,
  input  logic                is_last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SECS_W-1:0]   scaled_seconds_o,
  output logic [PLACES_W-1:0] decimal_places_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int WIDE_W = MANTISSA_BITS + 4;
  localparam int PROD_W = MANTISSA_BITS + MULT_W;
  localparam logic [PLACES_W-1:0] FRAC_LIM = PLACES_W'(MAX_FRAC_DIGITS);

  // input register
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_has_q;
  logic       in_last_q;

  // parse state
  logic [MANTISSA_BITS-1:0] mant_q, mant_d;
  logic [PLACES_W-1:0]      frac_q, frac_d;
  logic                     dot_q, dot_d;
  logic                     dig_q, dig_d;
  logic                     dot2_q, dot2_d;
  logic                     ovf_q, ovf_d;
  logic [7:0]               lns_q, lns_d;

  // snapshot of a finished specification
  logic                     fin_vld_q;
  logic [MANTISSA_BITS-1:0] fin_mant_q;
  logic [MULT_W-1:0]        fin_mult_q;
  logic [PLACES_W-1:0]      fin_places_q;
  status_e                  fin_status_q;

  // output register
  logic                out_vld_q;
  logic [SECS_W-1:0]   out_secs_q;
  logic [PLACES_W-1:0] out_places_q;
  status_e             out_status_q;

  logic out_ready, fin_ready, fire, in_ready, fin_take;

  assign out_ready = !out_vld_q || !out_stall_i;
  assign fin_ready = !fin_vld_q || out_ready;
  assign fire      = in_vld_q && (!in_last_q || fin_ready);
  assign fin_take  = fire && in_last_q;
  assign in_ready  = !in_vld_q || fire;
  assign in_stall_o = !in_ready;

  // ---- state update for the item in the input register ----
  logic [MANTISSA_BITS-1:0] up_mant;
  logic [PLACES_W-1:0]      up_frac;
  logic                     up_dot, up_dig, up_dot2, up_ovf;
  logic [7:0]               up_lns;
  logic [WIDE_W-1:0]        m_ext, m_x10;
  status_e                  up_status;

  assign m_ext = WIDE_W'(mant_q);
  assign m_x10 = (m_ext << 3) + (m_ext << 1) + WIDE_W'(in_char_q[3:0]);

  always_comb begin
    up_mant = mant_q;
    up_frac = frac_q;
    up_dot  = dot_q;
    up_dig  = dig_q;
    up_dot2 = dot2_q;
    up_ovf  = ovf_q;
    up_lns  = lns_q;
    if (in_has_q) begin
      if (is_digit(in_char_q)) begin
        up_dig = 1'b1;
        // excess fraction digits and post-overflow digits are dropped
        if (!(dot_q && frac_q >= FRAC_LIM) && !ovf_q) begin
          if (|m_x10[WIDE_W-1:MANTISSA_BITS]) begin
            up_ovf = 1'b1;
          end else begin
            up_mant = m_x10[MANTISSA_BITS-1:0];
            if (dot_q) begin
              up_frac = frac_q + PLACES_W'(1);
            end
          end
        end
      end else if (in_char_q == CHAR_DOT) begin
        if (dot_q) begin
          up_dot2 = 1'b1;
        end
        up_dot = 1'b1;
      end
      if (!is_space(in_char_q)) begin
        up_lns = in_char_q;
      end
    end
    if (!up_dig || up_dot2) begin
      up_status = STATUS_INVALID;
    end else if (up_ovf) begin
      up_status = STATUS_OVERFLOW;
    end else begin
      up_status = STATUS_OK;
    end
  end

  always_comb begin
    mant_d = mant_q;
    frac_d = frac_q;
    dot_d  = dot_q;
    dig_d  = dig_q;
    dot2_d = dot2_q;
    ovf_d  = ovf_q;
    lns_d  = lns_q;
    if (fire) begin
      if (in_last_q) begin
        mant_d = '0;
        frac_d = '0;
        dot_d  = 1'b0;
        dig_d  = 1'b0;
        dot2_d = 1'b0;
        ovf_d  = 1'b0;
        lns_d  = '0;
      end else begin
        mant_d = up_mant;
        frac_d = up_frac;
        dot_d  = up_dot;
        dig_d  = up_dig;
        dot2_d = up_dot2;
        ovf_d  = up_ovf;
        lns_d  = up_lns;
      end
    end
  end

  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(fin_mant_q) * PROD_W'(fin_mult_q);

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      mant_q    <= '0;
      frac_q    <= '0;
      dot_q     <= 1'b0;
      dig_q     <= 1'b0;
      dot2_q    <= 1'b0;
      ovf_q     <= 1'b0;
      lns_q     <= '0;
    end else begin
      if (in_ready) begin
        in_vld_q <= in_valid_i;
      end
      if (fin_take) begin
        fin_vld_q <= 1'b1;
      end else if (out_ready) begin
        fin_vld_q <= 1'b0;
      end
      if (out_ready) begin
        out_vld_q <= fin_vld_q;
      end
      mant_q <= mant_d;
      frac_q <= frac_d;
      dot_q  <= dot_d;
      dig_q  <= dig_d;
      dot2_q <= dot2_d;
      ovf_q  <= ovf_d;
      lns_q  <= lns_d;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_char_q <= char_code_i;
      in_has_q  <= has_char_i;
      in_last_q <= is_last_i;
    end
    if (fin_take) begin
      fin_status_q <= up_status;
      // error results carry zero fields
      if (up_status == STATUS_OK) begin
        fin_mant_q   <= up_mant;
        fin_places_q <= up_frac;
      end else begin
        fin_mant_q   <= '0;
        fin_places_q <= '0;
      end
      fin_mult_q <= unit_mult(up_lns);
    end
    if (out_ready && fin_vld_q) begin
      out_secs_q   <= SECS_W'(prod);
      out_places_q <= fin_places_q;
      out_status_q <= fin_status_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign scaled_seconds_o = out_secs_q;
  assign decimal_places_o = out_places_q;
  assign status_o         = out_status_q;

  // ---- assertions ----
  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q != STATUS_OK) |-> (out_secs_q == '0 && out_places_q == '0))
    else $error("error result with nonzero fields");

  a_places_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_places_q <= FRAC_LIM))
    else $error("decimal places beyond limit");

  a_frac_needs_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frac_q != '0) |-> dot_q)
    else $error("fraction digits counted without a dot");

  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && in_last_q && !fin_ready) |=> (in_vld_q && in_last_q && $stable(in_char_q)))
    else $error("blocked last item lost");

endmodule

### dv/tsp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsp_checker
// Watches both channels of the time specification parser. Every accepted
// character updates a private copy of the parse state; an item that ends a
// specification queues the expected duration. Each accepted result is
// compared field by field with the oldest queued duration.
// ---------------------------------------------------------------------------
module tsp_checker
  import tsp_pkg::*;
#(
  parameter int MANTISSA_BITS   = MANTISSA_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [7:0]          char_code_i,
  input  logic                has_char_i,
  input  logic                is_last_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [SECS_W-1:0]   scaled_seconds_i,
  input  logic [PLACES_W-1:0] decimal_places_i,
  input  logic [STATUS_W-1:0] status_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  n_ok_o,
  output int                  n_invalid_o,
  output int                  n_overflow_o
);

  localparam logic [63:0] MANT_MAX = (64'd1 << MANTISSA_BITS) - 64'd1;

  localparam logic [63:0] SECS_PER_MIN  = 64'd60;
  localparam logic [63:0] SECS_PER_HOUR = 64'd3600;
  localparam logic [63:0] SECS_PER_DAY  = 64'd86400;
  localparam logic [63:0] SECS_PER_WEEK = 64'd604800;

  typedef struct packed {
    logic [SECS_W-1:0]   secs;
    logic [PLACES_W-1:0] places;
    status_e             status;
  } duration_t;

  duration_t durations_q[$];

  // parse state of the specification in flight
  logic [63:0] mant;
  int unsigned frac_digits;
  logic        dot_seen, digit_seen, dot_twice, mant_ovf;
  logic [7:0]  last_mark;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic [63:0] suffix_factor(input logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? c + 8'd32 : c;
    case (lc)
      CHAR_LC_M: return SECS_PER_MIN;
      CHAR_LC_H: return SECS_PER_HOUR;
      CHAR_LC_D: return SECS_PER_DAY;
      CHAR_LC_W: return SECS_PER_WEEK;
      default:   return 64'd1;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    duration_t   want;
    logic [63:0] digit;
    if (!rst_ni) begin
      durations_q.delete();
      mant         = '0;
      frac_digits  = 0;
      dot_seen     = 1'b0;
      digit_seen   = 1'b0;
      dot_twice    = 1'b0;
      mant_ovf     = 1'b0;
      last_mark    = '0;
      errors_o     = 0;
      pending_o    = 0;
      n_ok_o       = 0;
      n_invalid_o  = 0;
      n_overflow_o = 0;
    end else begin
      // results first, so a new expectation never meets a result of this edge
      if (out_valid_i && !out_stall_i) begin
        if (durations_q.size() == 0) begin
          $error("result with no duration pending: scaled_seconds %0d, status %0d",
                 scaled_seconds_i, status_i);
          errors_o++;
        end else begin
          want = durations_q.pop_front();
          if (scaled_seconds_i !== want.secs) begin
            $error("scaled_seconds: expected %0d, actual %0d", want.secs, scaled_seconds_i);
            errors_o++;
          end
          if (decimal_places_i !== want.places) begin
            $error("decimal_places: expected %0d, actual %0d", want.places,
                   decimal_places_i);
            errors_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            errors_o++;
          end
          case (want.status)
            STATUS_OK:       n_ok_o++;
            STATUS_INVALID:  n_invalid_o++;
            default:         n_overflow_o++;
          endcase
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (has_char_i) begin
          if (char_code_i >= CHAR_ZERO && char_code_i <= CHAR_NINE) begin
            digit      = 64'(char_code_i - CHAR_ZERO);
            digit_seen = 1'b1;
            // excess fraction digits and digits after overflow are dropped
            if (!(dot_seen && frac_digits >= MAX_FRAC_DIGITS) && !mant_ovf) begin
              if (mant > (MANT_MAX - digit) / 64'd10) begin
                mant_ovf = 1'b1;
              end else begin
                mant = mant * 64'd10 + digit;
                if (dot_seen) frac_digits++;
              end
            end
          end else if (char_code_i == CHAR_DOT) begin
            if (dot_seen) dot_twice = 1'b1;
            dot_seen = 1'b1;
          end
          if (!is_blank(char_code_i)) last_mark = char_code_i;
        end

        if (is_last_i) begin
          want = '0;
          if (!digit_seen || dot_twice) begin
            want.status = STATUS_INVALID;
          end else if (mant_ovf) begin
            want.status = STATUS_OVERFLOW;
          end else begin
            want.status = STATUS_OK;
            want.secs   = mant * suffix_factor(last_mark);
            want.places = PLACES_W'(frac_digits);
          end
          durations_q.push_back(want);
          mant        = '0;
          frac_digits = 0;
          dot_seen    = 1'b0;
          digit_seen  = 1'b0;
          dot_twice   = 1'b0;
          mant_ovf    = 1'b0;
          last_mark   = '0;
        end
      end
      pending_o = durations_q.size();
    end
  end

endmodule

### dv/tb_time_spec_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_time_spec_parser
// Feeds time specifications to the parser one character per item: a few
// hand-written specifications covering minute, hour and day units and invalid text, then
// random well-formed durations mixed with noise and broken text. Both
// channels idle at random; once the result side holds off long enough to
// back up the block. The checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_time_spec_parser;
  import tsp_pkg::*;

  localparam int CLK_HALF_NS  = 10;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASE_ITEMS  = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          char_code_i;
  logic                has_char_i;
  logic                is_last_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [SECS_W-1:0]   scaled_seconds_o;
  logic [PLACES_W-1:0] decimal_places_o;
  logic [STATUS_W-1:0] status_o;

  int errors, pending, n_ok, n_invalid, n_overflow;

  // sender / receiver pacing
  bit tx_calm  = 1'b0;
  bit rx_calm  = 1'b0;
  bit hold_req = 1'b0;

  int   chars_sent = 0;
  int   specs_sent = 0;
  logic [7:0] spec_q[$];
  string unit_chars  = "smhdwSMHDW";
  string mixed_chars = "0123456789..  smhdwSMHDWx\t";

  always begin
    #(CLK_HALF_NS) clk_i = 1'b1;
    #(CLK_HALF_NS) clk_i = 1'b0;
  end

  time_spec_parser DUT (.*);

  tsp_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .char_code_i      (char_code_i),
    .has_char_i       (has_char_i),
    .is_last_i        (is_last_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scaled_seconds_i (scaled_seconds_o),
    .decimal_places_i (decimal_places_o),
    .status_i         (status_o),
    .errors_o         (errors),
    .pending_o        (pending),
    .n_ok_o           (n_ok),
    .n_invalid_o      (n_invalid),
    .n_overflow_o     (n_overflow)
  );

  // One item: optional idle gap, then hold it until the block takes it.
  task automatic put_item(input logic [7:0] code, input logic has, input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    has_char_i  <= has;
    is_last_i   <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (has || last) chars_sent++;
  endtask

  // Sends spec_q; an empty spec, or a noisy one now and then, ends on a
  // character-less last item. Noisy specs also get stray empty items.
  task automatic send_spec(input bit noisy);
    bit tail_empty;
    tail_empty = (spec_q.size() == 0) || (noisy && $urandom_range(0, 7) == 0);
    foreach (spec_q[k]) begin
      if (noisy && $urandom_range(0, 15) == 0) put_item(8'($urandom), 1'b0, 1'b0);
      put_item(spec_q[k], 1'b1, !tail_empty && (k == spec_q.size() - 1));
    end
    if (tail_empty) put_item(8'($urandom), 1'b0, 1'b1);
    specs_sent++;
  endtask

  task automatic load(input string s);
    spec_q.delete();
    for (int k = 0; k < s.len(); k++) spec_q.push_back(s[k]);
  endtask

  task automatic push_blank();
    int c;
    c = $urandom_range(9, 14);
    spec_q.push_back((c == 14) ? CHAR_SPACE : 8'(c));
  endtask

  task automatic push_digits(input int n);
    repeat (n) spec_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic build_spec();
    int kind, n;
    spec_q.delete();
    kind = $urandom_range(0, 15);
    if (kind < 11) begin
      // [blank] digits [. digits] [blank] [unit] [blank]
      if ($urandom_range(0, 3) == 0) push_blank();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 16) : $urandom_range(0, 5);
      push_digits(n);
      if ($urandom_range(0, 2) != 0) begin
        spec_q.push_back(CHAR_DOT);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 4);
        push_digits(n);
      end
      if ($urandom_range(0, 11) == 0) spec_q.insert($urandom_range(0, spec_q.size()), CHAR_DOT);
      if ($urandom_range(0, 3) == 0) push_blank();
      if ($urandom_range(0, 3) != 0) spec_q.push_back(unit_chars[$urandom_range(0, 9)]);
      if ($urandom_range(0, 2) == 0) push_blank();
    end else if (kind < 14) begin
      n = $urandom_range(1, 10);
      repeat (n) spec_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) spec_q.push_back(mixed_chars[$urandom_range(0, mixed_chars.len() - 1)]);
    end
  endtask

  // result side: random stall per result, one long hold-off on request
  initial begin : receiver
    int wait_n;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        wait_n = rx_calm ? 0 : $urandom_range(0, 6);
        if (wait_n > 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int target, phase_end, phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    has_char_i  = 1'b0;
    is_last_i   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-written cases
    load("");      send_spec(1'b0);              // empty spec
    put_item(8'hA5, 1'b0, 1'b0);                 // empty item, no result
    load("5m");    send_spec(1'b0);
    load("1.5H");  spec_q.push_back(CHAR_TAB); send_spec(1'b0);
    load("2..");   send_spec(1'b0);              // second dot
    load("3w");    spec_q.push_back(8'h00); send_spec(1'b0); // NUL clears suffix
    load("4D");    spec_q.push_back(CHAR_CR); send_spec(1'b0);
    load(" s");    send_spec(1'b0);              // suffix only
    load("8");     spec_q.push_back(8'hFF); send_spec(1'b0);

    // random phases with changing pacing; one phase backs up the output
    target = chars_sent + RANDOM_ITEMS;
    phase  = 0;
    while (chars_sent < target) begin
      phase_end = chars_sent + PHASE_ITEMS;
      tx_calm   = ($urandom_range(0, 3) == 0);
      rx_calm   = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        hold_req = 1'b1;
        tx_calm  = 1'b1;
      end
      while (chars_sent < phase_end || hold_req) begin
        build_spec();
        send_spec(1'b1);
      end
      phase++;
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d characters in %0d specifications, incl. a %0d-cycle output hold-off.",
             chars_sent, specs_sent, HOLD_CYCLES);
    $display("Checked %0d durations: %0d ok, %0d invalid, %0d overflow; %0d mismatches.",
             n_ok + n_invalid + n_overflow, n_ok, n_invalid, n_overflow, errors);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
